FILE: src/icd_pkg.sv
// shared constants for the accelerometer crash detector
package icd_pkg;

    localparam int HISTORY_DEPTH_DEF = 50;

    localparam int SAMPLE_W = 16;
    localparam int ENTRY_W  = 3 * SAMPLE_W;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SQ_CNT_W = 5;
    localparam logic [SQ_CNT_W-1:0] SQRT_LAST = SQ_CNT_W'(ROOT_W - 1);

    localparam int LIMIT_W     = 17;
    localparam int OFFSET_W    = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam int CONF_W  = 10;
    localparam int SPEED_W = 10;
    localparam int OUT_W   = 56;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMPACT_LIMIT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_OFFSET  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILT_Z_LIMIT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROLLOVER_CHANGE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RAPID_CHANGE    = 3'd4;

    localparam logic [LIMIT_W-1:0]  IMPACT_LIMIT_RST    = 17'd65536;
    localparam logic [OFFSET_W-1:0] GRAVITY_OFFSET_RST  = 15'd16384;
    localparam logic [OFFSET_W-1:0] TILT_Z_LIMIT_RST    = 15'd11585;
    localparam logic [LIMIT_W-1:0]  ROLLOVER_CHANGE_RST = 17'd16384;
    localparam logic [LIMIT_W-1:0]  RAPID_CHANGE_RST    = 17'd32768;

    // confidence = mag * 1000 / 163840 = mag * 25 >> 12
    localparam int CONF_PROD_W = 22;
    localparam int CONF_SHIFT  = 12;
    localparam logic [4:0]        CONF_MUL        = 5'd25;
    localparam logic [CONF_W-1:0] CONF_FULL       = 10'd1000;
    localparam logic [CONF_W-1:0] CONF_ROLL_FLOOR = 10'd700;

    // speed = (change * 981 >> 15) / 5, the divide by 5 as a reciprocal
    localparam int SPEED_PROD_W = 27;
    localparam int SPEED_SHIFT  = 15;
    localparam int SPEED_Q_W    = SPEED_PROD_W - SPEED_SHIFT;
    localparam int DIV5_PROD_W  = 28;
    localparam int DIV5_SHIFT   = 18;
    localparam logic [9:0]  SPEED_NUM = 10'd981;
    localparam logic [15:0] DIV5_MUL  = 16'd52429;

endpackage

FILE: src/imu_crash_detector.sv
// accelerometer crash detector: impact, rollover and history change per sample
//
// usage:
//   s_axis carries one raw sample (x, y, z, 16384 counts per g) per item.
//   m_axis returns one result item per sample, in order.
//   cfg writes one of five limit registers; write only while the block is idle.
// flow:
//   each item sweeps the history through the squared-distance unit at one entry a
//   cycle, then takes the bit-serial square root of the largest change; for very
//   small depths that root waits for the magnitude root to finish first.
//   s_axis_tready is high only between items.
// reset:
//   limits take their default values, the write slot goes to zero and every
//   history entry reads as zero until written (valid bits, no clearing pass).
// stall:
//   the result sits in an output register; the next sample is taken while it
//   waits, and that sample's result holds in the last step until m_axis drains.
module imu_crash_detector
    import icd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [ENTRY_W-1:0]     s_axis_tdata,   // accel_x, accel_y, accel_z
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,   // crash_detected, impact_force,
                                                   // rollover_flag, max_change,
                                                   // speed_delta, confidence
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_SWEEP,
        ST_DRAIN,
        ST_ROOT,
        ST_ROOT_WAIT,
        ST_SCALE,
        ST_SPEED,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         slot_reg, slot_next;
    logic [IDX_W-1:0]         written_reg, written_next;
    logic [HISTORY_DEPTH-1:0] hvalid_reg, hvalid_next;

    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic [SAMPLE_W-1:0] y_reg, y_next;
    logic [SAMPLE_W-1:0] z_reg, z_next;

    logic [LIMIT_W-1:0]  impact_limit_reg, impact_limit_next;
    logic [OFFSET_W-1:0] gravity_offset_reg, gravity_offset_next;
    logic [OFFSET_W-1:0] tilt_z_limit_reg, tilt_z_limit_next;
    logic [LIMIT_W-1:0]  rollover_change_reg, rollover_change_next;
    logic [LIMIT_W-1:0]  rapid_change_reg, rapid_change_next;

    logic s1_valid_reg, s1_valid_next;
    logic s1_mag_reg, s1_mag_next;
    logic s1_use_reg, s1_use_next;
    logic s1_hvalid_reg, s1_hvalid_next;

    logic            s2_valid_reg, s2_valid_next;
    logic            s2_mag_reg, s2_mag_next;
    logic            s2_use_reg, s2_use_next;
    logic [SQ_W-1:0] s2_sq0_reg, s2_sq0_next;
    logic [SQ_W-1:0] s2_sq1_reg, s2_sq1_next;
    logic [SQ_W-1:0] s2_sq2_reg, s2_sq2_next;

    logic [SUM_W-1:0] maxsq_reg, maxsq_next;

    logic                sq_busy_reg, sq_busy_next;
    logic                sq_dst_max_reg, sq_dst_max_next;
    logic [SQ_CNT_W-1:0] sq_cnt_reg, sq_cnt_next;
    logic [SUM_W-1:0]    sq_n_reg, sq_n_next;
    logic [REM_W-1:0]    sq_rem_reg, sq_rem_next;
    logic [ROOT_W-1:0]   sq_root_reg, sq_root_next;

    logic [ROOT_W-1:0]       mag_reg, mag_next;
    logic [ROOT_W-1:0]       maxc_reg, maxc_next;
    logic [CONF_PROD_W-1:0]  conf_prod_reg, conf_prod_next;
    logic [SPEED_PROD_W-1:0] spd_prod_reg, spd_prod_next;
    logic [DIV5_PROD_W-1:0]  spd_div_reg, spd_div_next;

    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic               in_accept;
    logic               issue_valid;
    logic               issue_mag;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_data;

    logic [SAMPLE_W-1:0] hx, hy, hz;
    logic [DIFF_W-1:0]   op0, op1, op2;
    logic [SAMPLE_W-1:0] abs0, abs1, abs2;
    logic [SUM_W-1:0]    sum;

    logic                  sq_done;
    logic [REM_W+1:0]      sq_rem_sh;
    logic [REM_W+1:0]      sq_trial;
    logic [REM_W-1:0]      sq_rem_step;
    logic [ROOT_W-1:0]     sq_root_step;

    logic                  impact;
    logic                  roll;
    logic [SAMPLE_W-1:0]   absz;
    logic [CONF_W-1:0]     conf_raw;
    logic [CONF_W-1:0]     conf;
    logic [SPEED_W-1:0]    speed;
    logic [SPEED_Q_W-1:0]  spd_q;
    logic                  crash;
    logic                  out_load;

    function automatic logic [SAMPLE_W-1:0] abs_diff(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] n;
        n = ~d + DIFF_W'(1);
        return d[DIFF_W-1] ? n[SAMPLE_W-1:0] : d[SAMPLE_W-1:0];
    endfunction

    icd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (slot_reg),
        .wr_data (s_axis_tdata),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign issue_mag   = (state_reg == ST_MAG);
    assign rd_en       = (state_reg == ST_SWEEP);
    assign issue_valid = issue_mag || rd_en;

    // stage 1: differences against the history entry, or the gravity-corrected sample
    assign hx = s1_hvalid_reg ? rd_data[SAMPLE_W-1:0] : '0;
    assign hy = s1_hvalid_reg ? rd_data[2*SAMPLE_W-1:SAMPLE_W] : '0;
    assign hz = s1_hvalid_reg ? rd_data[3*SAMPLE_W-1:2*SAMPLE_W] : '0;

    always_comb
    begin
        if (s1_mag_reg)
        begin
            op0 = {x_reg[SAMPLE_W-1], x_reg};
            op1 = {y_reg[SAMPLE_W-1], y_reg};
            op2 = {z_reg[SAMPLE_W-1], z_reg} - {2'b00, gravity_offset_reg};
        end
        else
        begin
            op0 = {x_reg[SAMPLE_W-1], x_reg} - {hx[SAMPLE_W-1], hx};
            op1 = {y_reg[SAMPLE_W-1], y_reg} - {hy[SAMPLE_W-1], hy};
            op2 = {z_reg[SAMPLE_W-1], z_reg} - {hz[SAMPLE_W-1], hz};
        end
    end

    assign abs0 = abs_diff(op0);
    assign abs1 = abs_diff(op1);
    assign abs2 = abs_diff(op2);

    // stage 2: sum of squares
    assign sum = {2'b00, s2_sq0_reg} + {2'b00, s2_sq1_reg} + {2'b00, s2_sq2_reg};

    // one root bit per cycle
    assign sq_done   = sq_busy_reg && (sq_cnt_reg == SQRT_LAST);
    assign sq_rem_sh = {sq_rem_reg, sq_n_reg[SUM_W-1:SUM_W-2]};
    assign sq_trial  = {2'b00, sq_root_reg, 2'b01};

    always_comb
    begin
        if (sq_rem_sh >= sq_trial)
        begin
            sq_rem_step  = REM_W'(sq_rem_sh - sq_trial);
            sq_root_step = {sq_root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            sq_rem_step  = sq_rem_sh[REM_W-1:0];
            sq_root_step = {sq_root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // result assembly
    assign impact   = (mag_reg >= impact_limit_reg);
    assign absz     = z_reg[SAMPLE_W-1] ? (~z_reg + SAMPLE_W'(1)) : z_reg;
    assign roll     = (absz < {1'b0, tilt_z_limit_reg});
    assign conf_raw = conf_prod_reg[CONF_PROD_W-1:CONF_SHIFT];
    assign spd_q    = spd_prod_reg[SPEED_PROD_W-1:SPEED_SHIFT];
    assign crash    = impact || (roll && (maxc_reg > rollover_change_reg));
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        conf = '0;
        if (impact)
        begin
            conf = (conf_raw > CONF_FULL) ? CONF_FULL : conf_raw;
        end
        if (roll && (conf < CONF_ROLL_FLOOR))
        begin
            conf = CONF_ROLL_FLOOR;
        end
        speed = '0;
        if (maxc_reg > rapid_change_reg)
        begin
            speed = spd_div_reg[DIV5_PROD_W-1:DIV5_SHIFT];
        end
    end

    always_comb
    begin
        state_next           = state_reg;
        cnt_next             = cnt_reg;
        slot_next            = slot_reg;
        written_next         = written_reg;
        hvalid_next          = hvalid_reg;
        x_next               = x_reg;
        y_next               = y_reg;
        z_next               = z_reg;
        impact_limit_next    = impact_limit_reg;
        gravity_offset_next  = gravity_offset_reg;
        tilt_z_limit_next    = tilt_z_limit_reg;
        rollover_change_next = rollover_change_reg;
        rapid_change_next    = rapid_change_reg;
        maxsq_next           = maxsq_reg;
        sq_busy_next         = sq_busy_reg;
        sq_dst_max_next      = sq_dst_max_reg;
        sq_cnt_next          = sq_cnt_reg;
        sq_n_next            = sq_n_reg;
        sq_rem_next          = sq_rem_reg;
        sq_root_next         = sq_root_reg;
        mag_next             = mag_reg;
        maxc_next            = maxc_reg;
        conf_prod_next       = conf_prod_reg;
        spd_prod_next        = spd_prod_reg;
        spd_div_next         = spd_div_reg;
        out_valid_next       = out_valid_reg;
        out_data_next        = out_data_reg;

        // pipeline of the squared-distance unit
        s1_valid_next  = issue_valid;
        s1_mag_next    = issue_mag;
        s1_use_next    = (cnt_reg != written_reg);
        s1_hvalid_next = hvalid_reg[cnt_reg];
        s2_valid_next  = s1_valid_reg;
        s2_mag_next    = s1_mag_reg;
        s2_use_next    = s1_use_reg;
        s2_sq0_next    = abs0 * abs0;
        s2_sq1_next    = abs1 * abs1;
        s2_sq2_next    = abs2 * abs2;

        if (s2_valid_reg && !s2_mag_reg && s2_use_reg && (sum > maxsq_reg))
        begin
            maxsq_next = sum;
        end

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMPACT_LIMIT:    impact_limit_next    = cfg_data[LIMIT_W-1:0];
                REG_GRAVITY_OFFSET:  gravity_offset_next  = cfg_data[OFFSET_W-1:0];
                REG_TILT_Z_LIMIT:    tilt_z_limit_next    = cfg_data[OFFSET_W-1:0];
                REG_ROLLOVER_CHANGE: rollover_change_next = cfg_data[LIMIT_W-1:0];
                REG_RAPID_CHANGE:    rapid_change_next    = cfg_data[LIMIT_W-1:0];
                default:             ;
            endcase
        end

        // square root unit
        if (sq_busy_reg)
        begin
            sq_rem_next  = sq_rem_step;
            sq_root_next = sq_root_step;
            sq_n_next    = {sq_n_reg[SUM_W-3:0], 2'b00};
            sq_cnt_next  = sq_cnt_reg + SQ_CNT_W'(1);
            if (sq_done)
            begin
                sq_busy_next = 1'b0;
                if (sq_dst_max_reg)
                begin
                    maxc_next = sq_root_step;
                end
                else
                begin
                    mag_next = sq_root_step;
                end
            end
        end
        if (s2_valid_reg && s2_mag_reg)
        begin
            sq_busy_next    = 1'b1;
            sq_dst_max_next = 1'b0;
            sq_n_next       = sum;
            sq_rem_next     = '0;
            sq_root_next    = '0;
            sq_cnt_next     = '0;
        end
        if ((state_reg == ST_ROOT) && !sq_busy_reg)
        begin
            sq_busy_next    = 1'b1;
            sq_dst_max_next = 1'b1;
            sq_n_next       = maxsq_reg;
            sq_rem_next     = '0;
            sq_root_next    = '0;
            sq_cnt_next     = '0;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_next               = s_axis_tdata[SAMPLE_W-1:0];
                    y_next               = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    z_next               = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
                    written_next         = slot_reg;
                    hvalid_next[slot_reg] = 1'b1;
                    slot_next            = (slot_reg == LAST_IDX) ? '0 : slot_reg + IDX_W'(1);
                    maxsq_next           = '0;
                    cnt_next             = '0;
                    state_next           = ST_MAG;
                end
            end
            ST_MAG:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (!sq_busy_reg)
                begin
                    state_next = ST_ROOT_WAIT;
                end
            end
            ST_ROOT_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                conf_prod_next = CONF_PROD_W'(mag_reg) * CONF_PROD_W'(CONF_MUL);
                spd_prod_next  = SPEED_PROD_W'(maxc_reg) * SPEED_PROD_W'(SPEED_NUM);
                state_next     = ST_SPEED;
            end
            ST_SPEED:
            begin
                spd_div_next = DIV5_PROD_W'(spd_q) * DIV5_PROD_W'(DIV5_MUL);
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {conf, speed, maxc_reg, roll,
                                      (impact ? mag_reg : {ROOT_W{1'b0}}), crash};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            cnt_reg             <= '0;
            slot_reg            <= '0;
            written_reg         <= '0;
            hvalid_reg          <= '0;
            x_reg               <= '0;
            y_reg               <= '0;
            z_reg               <= '0;
            impact_limit_reg    <= IMPACT_LIMIT_RST;
            gravity_offset_reg  <= GRAVITY_OFFSET_RST;
            tilt_z_limit_reg    <= TILT_Z_LIMIT_RST;
            rollover_change_reg <= ROLLOVER_CHANGE_RST;
            rapid_change_reg    <= RAPID_CHANGE_RST;
            s1_valid_reg        <= 1'b0;
            s1_mag_reg          <= 1'b0;
            s1_use_reg          <= 1'b0;
            s1_hvalid_reg       <= 1'b0;
            s2_valid_reg        <= 1'b0;
            s2_mag_reg          <= 1'b0;
            s2_use_reg          <= 1'b0;
            s2_sq0_reg          <= '0;
            s2_sq1_reg          <= '0;
            s2_sq2_reg          <= '0;
            maxsq_reg           <= '0;
            sq_busy_reg         <= 1'b0;
            sq_dst_max_reg      <= 1'b0;
            sq_cnt_reg          <= '0;
            sq_n_reg            <= '0;
            sq_rem_reg          <= '0;
            sq_root_reg         <= '0;
            mag_reg             <= '0;
            maxc_reg            <= '0;
            conf_prod_reg       <= '0;
            spd_prod_reg        <= '0;
            spd_div_reg         <= '0;
            out_valid_reg       <= 1'b0;
            out_data_reg        <= '0;
        end
        else
        begin
            state_reg           <= state_next;
            cnt_reg             <= cnt_next;
            slot_reg            <= slot_next;
            written_reg         <= written_next;
            hvalid_reg          <= hvalid_next;
            x_reg               <= x_next;
            y_reg               <= y_next;
            z_reg               <= z_next;
            impact_limit_reg    <= impact_limit_next;
            gravity_offset_reg  <= gravity_offset_next;
            tilt_z_limit_reg    <= tilt_z_limit_next;
            rollover_change_reg <= rollover_change_next;
            rapid_change_reg    <= rapid_change_next;
            s1_valid_reg        <= s1_valid_next;
            s1_mag_reg          <= s1_mag_next;
            s1_use_reg          <= s1_use_next;
            s1_hvalid_reg       <= s1_hvalid_next;
            s2_valid_reg        <= s2_valid_next;
            s2_mag_reg          <= s2_mag_next;
            s2_use_reg          <= s2_use_next;
            s2_sq0_reg          <= s2_sq0_next;
            s2_sq1_reg          <= s2_sq1_next;
            s2_sq2_reg          <= s2_sq2_next;
            maxsq_reg           <= maxsq_next;
            sq_busy_reg         <= sq_busy_next;
            sq_dst_max_reg      <= sq_dst_max_next;
            sq_cnt_reg          <= sq_cnt_next;
            sq_n_reg            <= sq_n_next;
            sq_rem_reg          <= sq_rem_next;
            sq_root_reg         <= sq_root_next;
            mag_reg             <= mag_next;
            maxc_reg            <= maxc_next;
            conf_prod_reg       <= conf_prod_next;
            spd_prod_reg        <= spd_prod_next;
            spd_div_reg         <= spd_div_next;
            out_valid_reg       <= out_valid_next;
            out_data_reg        <= out_data_next;
        end
    end

endmodule

FILE: src/icd_ram.sv
// generic simple dual-port ram with registered read
module icd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 50
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: tb/imu_crash_detector_tb.sv
// self-checking testbench for the accelerometer crash detector
`timescale 1ns / 1ps

module imu_crash_detector_tb;
    import icd_pkg::*;

    localparam int HIST_DEPTH   = HISTORY_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int END_PAUSE    = 120;
    localparam int PRINT_LIMIT  = 40;
    localparam longint TEN_G    = 163840;
    localparam longint CONF_MAX = 1000;
    localparam longint CONF_ROLL = 700;
    localparam longint KMH_NUM  = 981;

    typedef struct packed {
        logic [CONF_W-1:0]  confidence;
        logic [SPEED_W-1:0] speed_delta;
        logic [16:0]        max_change;
        logic               rollover_flag;
        logic [16:0]        impact_force;
        logic               crash_detected;
    } crash_report_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [ENTRY_W-1:0]     s_axis_tdata;   // accel_x, accel_y, accel_z
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_W-1:0]       m_axis_tdata;   // crash_detected, impact_force, rollover_flag,
                                            // max_change, speed_delta, confidence
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    imu_crash_detector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    logic [LIMIT_W-1:0]  lim_impact   = IMPACT_LIMIT_RST;
    logic [OFFSET_W-1:0] grav_off     = GRAVITY_OFFSET_RST;
    logic [OFFSET_W-1:0] tilt_lim     = TILT_Z_LIMIT_RST;
    logic [LIMIT_W-1:0]  lim_roll_chg = ROLLOVER_CHANGE_RST;
    logic [LIMIT_W-1:0]  lim_rapid    = RAPID_CHANGE_RST;
    logic signed [15:0]  hist_x [HIST_DEPTH];
    logic signed [15:0]  hist_y [HIST_DEPTH];
    logic signed [15:0]  hist_z [HIST_DEPTH];
    int                  next_slot = 0;

    crash_report_t pending_reports [$];
    int            fail_count   = 0;
    int            result_count = 0;
    int            cycle_count  = 0;
    bit            burst_mode   = 1'b0;
    logic [15:0]   last_x = '0;
    logic [15:0]   last_y = '0;
    logic [15:0]   last_z = '0;

    initial
    begin
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            hist_x[i] = '0;
            hist_y[i] = '0;
            hist_z[i] = '0;
        end
    end

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("imu_crash_detector_tb NOT OK");
            $finish;
        end
    end

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        longint unsigned rest;
        root  = 0;
        rest  = n;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rest)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned dist3(input longint dx, input longint dy,
                                              input longint dz);
        return floor_root(longint'(dx * dx + dy * dy + dz * dz));
    endfunction

    function automatic crash_report_t judge_sample(input logic signed [15:0] ax,
                                                   input logic signed [15:0] ay,
                                                   input logic signed [15:0] az);
        crash_report_t   r;
        longint unsigned mag;
        longint unsigned change;
        longint unsigned d;
        longint unsigned conf;
        longint unsigned speed;
        longint          absz;
        bit              impact;
        bit              roll;
        int              slot;
        mag    = dist3(longint'(ax), longint'(ay), longint'(az) - longint'(grav_off));
        impact = mag >= longint'(lim_impact);
        absz   = (az < 0) ? -longint'(az) : longint'(az);
        roll   = absz < longint'(tilt_lim);
        conf   = 0;
        if (impact)
        begin
            conf = mag * CONF_MAX / TEN_G;
            if (conf > CONF_MAX)
                conf = CONF_MAX;
        end
        if (roll && conf < CONF_ROLL)
            conf = CONF_ROLL;

        slot         = next_slot;
        hist_x[slot] = ax;
        hist_y[slot] = ay;
        hist_z[slot] = az;
        next_slot    = (slot + 1) % HIST_DEPTH;

        change = 0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            if (i != slot)
            begin
                d = dist3(longint'(ax) - longint'(hist_x[i]),
                          longint'(ay) - longint'(hist_y[i]),
                          longint'(az) - longint'(hist_z[i]));
                if (d > change)
                    change = d;
            end
        end
        speed = (change > longint'(lim_rapid)) ? change * KMH_NUM / TEN_G : 0;

        r.crash_detected = impact || (roll && change > longint'(lim_roll_chg));
        r.impact_force   = impact ? mag[16:0] : '0;
        r.rollover_flag  = roll;
        r.max_change     = change[16:0];
        r.speed_delta    = speed[SPEED_W-1:0];
        r.confidence     = conf[CONF_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch at result %0d, %s: got %0d, expected %0d",
                     result_count, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        crash_report_t got;
        crash_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = crash_report_t'(m_axis_tdata);
            if (pending_reports.size() == 0)
                report_mismatch("item with nothing expected", got, 0);
            else
            begin
                want = pending_reports.pop_front();
                if (got.crash_detected !== want.crash_detected)
                    report_mismatch("crash_detected", got.crash_detected,
                                    want.crash_detected);
                if (got.impact_force !== want.impact_force)
                    report_mismatch("impact_force", got.impact_force, want.impact_force);
                if (got.rollover_flag !== want.rollover_flag)
                    report_mismatch("rollover_flag", got.rollover_flag, want.rollover_flag);
                if (got.max_change !== want.max_change)
                    report_mismatch("max_change", got.max_change, want.max_change);
                if (got.speed_delta !== want.speed_delta)
                    report_mismatch("speed_delta", got.speed_delta, want.speed_delta);
                if (got.confidence !== want.confidence)
                    report_mismatch("confidence", got.confidence, want.confidence);
            end
            result_count++;
        end
    end

    // result side backpressure
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = burst_mode ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {az, ay, ax};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_reports.push_back(judge_sample(ax, ay, az));
        last_x = ax;
        last_y = ay;
        last_z = az;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // call only with the block idle
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_IMPACT_LIMIT:    lim_impact   = value[LIMIT_W-1:0];
            REG_GRAVITY_OFFSET:  grav_off     = value[OFFSET_W-1:0];
            REG_TILT_Z_LIMIT:    tilt_lim     = value[OFFSET_W-1:0];
            REG_ROLLOVER_CHANGE: lim_roll_chg = value[LIMIT_W-1:0];
            REG_RAPID_CHANGE:    lim_rapid    = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] impact,
                             input logic [CFG_DATA_W-1:0] offset,
                             input logic [CFG_DATA_W-1:0] tilt,
                             input logic [CFG_DATA_W-1:0] roll_chg,
                             input logic [CFG_DATA_W-1:0] rapid);
        write_reg(REG_IMPACT_LIMIT, impact);
        write_reg(REG_GRAVITY_OFFSET, offset);
        write_reg(REG_TILT_Z_LIMIT, tilt);
        write_reg(REG_ROLLOVER_CHANGE, roll_chg);
        write_reg(REG_RAPID_CHANGE, rapid);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_limit(input int typical);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'(typical);
            3:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 2 * typical));
        endcase
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return 16'hffff;
        endcase
    endfunction

    function automatic logic [15:0] pick_large();
        int v;
        v = $urandom_range(20000, 32767);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return 16'(v);
    endfunction

    task automatic send_random_sample();
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        case ($urandom_range(0, 9))
            3, 4:
            begin
                ax = 16'(int'($urandom_range(0, 4000)) - 2000);
                ay = 16'(int'($urandom_range(0, 4000)) - 2000);
                az = 16'(int'($urandom_range(14384, 18384)));
            end
            5:
            begin
                ax = 16'(int'($urandom_range(0, 40000)) - 20000);
                ay = 16'(int'($urandom_range(0, 40000)) - 20000);
                az = 16'(int'($urandom_range(0, 24000)) - 12000);
            end
            6:
            begin
                ax = pick_extreme();
                ay = pick_extreme();
                az = pick_extreme();
            end
            7:
            begin
                ax = last_x;
                ay = last_y;
                az = last_z;
            end
            8:
            begin
                ax = pick_large();
                ay = pick_large();
                az = pick_large();
            end
            default:
            begin
                ax = 16'($urandom);
                ay = 16'($urandom);
                az = 16'($urandom);
            end
        endcase
        send_sample(ax, ay, az);
    endtask

    task automatic random_config();
        write_reg(REG_IMPACT_LIMIT, pick_limit(IMPACT_LIMIT_RST));
        write_reg(REG_GRAVITY_OFFSET, pick_limit(GRAVITY_OFFSET_RST));
        write_reg(REG_TILT_Z_LIMIT, pick_limit(TILT_Z_LIMIT_RST));
        write_reg(REG_ROLLOVER_CHANGE, pick_limit(ROLLOVER_CHANGE_RST));
        write_reg(REG_RAPID_CHANGE, pick_limit(RAPID_CHANGE_RST));
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_INDEX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom));
    endtask

    // defaults, zero history, extremes of the axes and the tilt boundary
    task automatic test_defaults_after_reset();
        send_sample(16'd0, 16'd0, 16'd16384);
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h7fff);
        send_sample(16'h8000, 16'h7fff, 16'd0);
        send_sample(16'd0, 16'd0, 16'd11584);
        send_sample(16'd0, 16'd0, 16'd11585);
        send_sample(16'd0, 16'd0, -16'sd11585);
        send_sample(16'd0, 16'd0, -16'sd11584);
        wait_for_results();
    endtask

    // exact thresholds, register extremes, masking and unused indexes
    task automatic test_register_limits();
        write_all(17'd5, 17'd100, 17'd100, ROLLOVER_CHANGE_RST, RAPID_CHANGE_RST);
        send_sample(16'd3, 16'd4, 16'd100);
        send_sample(16'd3, 16'd4, 16'd99);
        wait_for_results();
        write_reg(REG_IMPACT_LIMIT, 17'd6);
        send_sample(16'd3, 16'd4, 16'd100);
        wait_for_results();

        write_all(17'd0, 17'd32767, 17'd32767, 17'd0, 17'd0);
        send_sample(16'h7fff, 16'h8000, 16'h8000);
        send_sample(16'd0, 16'd0, -16'sd32767);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        wait_for_results();

        write_all('1, 17'd0, 17'd0, '1, '1);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'd0, 16'd0, 16'd0);
        wait_for_results();

        write_reg(3'd5, '1);
        write_reg(3'd6, CFG_DATA_W'($urandom));
        write_reg(3'd7, 17'h15555);
        write_reg(REG_GRAVITY_OFFSET, 17'h1ffff);
        write_reg(REG_TILT_Z_LIMIT, 17'h18000);
        send_sample(16'd0, 16'd0, 16'd0);
        wait_for_results();
        write_all(IMPACT_LIMIT_RST, GRAVITY_OFFSET_RST, TILT_Z_LIMIT_RST,
                  ROLLOVER_CHANGE_RST, RAPID_CHANGE_RST);
    endtask

    task automatic test_random_settings(input int phases, input int items);
        for (int p = 0; p < phases; p++)
        begin
            if (p > 0)
            begin
                wait_for_results();
                random_config();
            end
            repeat (items) send_random_sample();
        end
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        burst_mode = 1'b1;
        repeat (60) send_random_sample();
        wait_for_results();
        burst_mode = 1'b0;
    endtask

    task automatic test_pause_for_results();
        repeat (30) send_random_sample();
        wait_for_results();
        repeat (30) send_random_sample();
        wait_for_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_defaults_after_reset();
        test_register_limits();
        test_random_settings(1, 120);
        test_back_to_back();
        test_random_settings(6, 90);
        test_pause_for_results();

        wait_for_results();
        repeat (END_PAUSE) @(posedge clk);
        if (pending_reports.size() != 0)
            report_mismatch("items still expected", 0, pending_reports.size());
        if (fail_count == 0)
            $display("imu_crash_detector_tb OK");
        else
            $display("imu_crash_detector_tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
src/icd_pkg.sv
src/icd_ram.sv
src/imu_crash_detector.sv
tb/imu_crash_detector_tb.sv
